### hw/rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### hw/rtl/gha_pkg.sv
// Package for the generational handle allocator: widths, codes, types, handle packing.
package gha_pkg;

    localparam int INDEX_WIDTH  = 10;
    localparam int GEN_WIDTH    = 22;
    localparam int HANDLE_WIDTH = 32;
    localparam int SLOT_COUNT   = 1 << INDEX_WIDTH;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_CHECK = 2'd2;

    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_INVALID = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    typedef logic [INDEX_WIDTH-1:0]  t_index;
    typedef logic [INDEX_WIDTH:0]    t_count;
    typedef logic [GEN_WIDTH-1:0]    t_gen;
    typedef logic [HANDLE_WIDTH-1:0] t_handle;

    typedef struct packed {
        logic alive;
        t_gen gen;
    } t_slot;

    typedef struct packed {
        logic   push;
        logic   pop;
        t_index push_idx;
    } t_stack_cmd;

    function automatic t_handle make_handle(t_gen gen, t_index idx);
        logic [GEN_WIDTH+INDEX_WIDTH+HANDLE_WIDTH-1:0] wide;
        wide = {{HANDLE_WIDTH{1'b0}}, gen, idx};
        return wide[HANDLE_WIDTH-1:0];
    endfunction

endpackage

### hw/rtl/gha_free_stack.sv
// LIFO stack of freed slot indexes in a synchronous memory with a fill count.
module gha_free_stack (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gha_pkg::t_stack_cmd i_cmd,
    output gha_pkg::t_count     o_count,
    output gha_pkg::t_index     o_top
);

    gha_pkg::t_index r_mem [gha_pkg::SLOT_COUNT];
    gha_pkg::t_count r_count;
    gha_pkg::t_count n_count;
    gha_pkg::t_count w_count_m1;
    gha_pkg::t_index r_top;

    assign w_count_m1 = r_count - 1'b1;

    always_comb begin
        n_count = r_count;
        if (i_cmd.pop) begin
            n_count = w_count_m1;
        end else if (i_cmd.push) begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_count[gha_pkg::INDEX_WIDTH-1:0]] <= i_cmd.push_idx;
        end
        if (i_cmd.pop) begin
            r_top <= r_mem[w_count_m1[gha_pkg::INDEX_WIDTH-1:0]];
        end
    end

    assign o_count = r_count;
    assign o_top   = r_top;

endmodule

### hw/rtl/generational_handle_allocator_unit.sv
// Sequencing: a fresh allocate, full table or unused op is answered straight from idle; free and
// check read the slot memory first (ST_SLOT); an allocate from the free stack pops it (ST_POP), then reads the slot.
// Requests: busy stays high until the result is issued, so each item completes before the next is taken;
// the pace is set by the serial free-stack read followed by the slot memory read-modify-write.
// Reset: synchronous, active low; clears the sequencer, fill counts and result strobe.
// Memory contents are not cleared; no clearing pass, a slot read beyond the used count is ignored by the check.
module generational_handle_allocator_unit (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               i_op,
    input  logic [gha_pkg::HANDLE_WIDTH-1:0] i_handle,
    output logic                     o_done,
    output logic [1:0]               o_status,
    output logic [gha_pkg::HANDLE_WIDTH-1:0] o_new_handle,
    output logic                     o_is_valid
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_POP  = 2'd1;
    localparam logic [1:0] ST_SLOT = 2'd2;

    logic [1:0]          r_state;
    logic [1:0]          n_state;
    logic [1:0]          r_op;
    gha_pkg::t_handle    r_handle;
    gha_pkg::t_index     r_idx;
    gha_pkg::t_count     r_slots_used;
    gha_pkg::t_count     n_slots_used;

    gha_pkg::t_slot      r_slot_mem [gha_pkg::SLOT_COUNT];
    gha_pkg::t_slot      r_slot_q;
    logic                slot_rd_en;
    gha_pkg::t_index     slot_rd_addr;
    logic                slot_wr_en;
    gha_pkg::t_index     slot_wr_addr;
    gha_pkg::t_slot      slot_wr_data;

    gha_pkg::t_stack_cmd stack_cmd;
    gha_pkg::t_count     stack_count;
    gha_pkg::t_index     stack_top;

    logic                res_valid;
    logic [1:0]          res_status;
    gha_pkg::t_handle    res_handle;
    logic                res_is_valid;
    logic                cur;

    logic                r_done;
    logic [1:0]          r_status;
    gha_pkg::t_handle    r_new_handle;
    logic                r_is_valid;

    gha_free_stack u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (stack_cmd),
        .o_count (stack_count),
        .o_top   (stack_top)
    );

    assign busy = (r_state != ST_IDLE);

    assign cur = ({1'b0, r_idx} < r_slots_used) && r_slot_q.alive
                 && (gha_pkg::make_handle(r_slot_q.gen, r_idx) == r_handle);

    always_comb begin
        n_state      = r_state;
        n_slots_used = r_slots_used;
        stack_cmd    = '0;
        slot_rd_en   = 1'b0;
        slot_rd_addr = r_idx;
        slot_wr_en   = 1'b0;
        slot_wr_addr = r_idx;
        slot_wr_data = '0;
        res_valid    = 1'b0;
        res_status   = gha_pkg::STATUS_INVALID;
        res_handle   = '0;
        res_is_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    case (i_op)
                        gha_pkg::OP_ALLOC: begin
                            if (stack_count != '0) begin
                                stack_cmd.pop = 1'b1;
                                n_state       = ST_POP;
                            end else if (r_slots_used <
                                         gha_pkg::t_count'(gha_pkg::SLOT_COUNT)) begin
                                slot_wr_en         = 1'b1;
                                slot_wr_addr       = r_slots_used[gha_pkg::INDEX_WIDTH-1:0];
                                slot_wr_data.alive = 1'b1;
                                slot_wr_data.gen   = '0;
                                n_slots_used       = r_slots_used + 1'b1;
                                res_valid          = 1'b1;
                                res_status         = gha_pkg::STATUS_DONE;
                                res_handle         = gha_pkg::make_handle(
                                    '0, r_slots_used[gha_pkg::INDEX_WIDTH-1:0]);
                            end else begin
                                res_valid  = 1'b1;
                                res_status = gha_pkg::STATUS_FULL;
                            end
                        end
                        gha_pkg::OP_FREE, gha_pkg::OP_CHECK: begin
                            slot_rd_en   = 1'b1;
                            slot_rd_addr = i_handle[gha_pkg::INDEX_WIDTH-1:0];
                            n_state      = ST_SLOT;
                        end
                        default: begin
                            res_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_POP: begin
                slot_rd_en   = 1'b1;
                slot_rd_addr = stack_top;
                n_state      = ST_SLOT;
            end
            ST_SLOT: begin
                n_state   = ST_IDLE;
                res_valid = 1'b1;
                case (r_op)
                    gha_pkg::OP_ALLOC: begin
                        slot_wr_en         = 1'b1;
                        slot_wr_data.alive = 1'b1;
                        slot_wr_data.gen   = r_slot_q.gen;
                        res_status         = gha_pkg::STATUS_DONE;
                        res_handle         = gha_pkg::make_handle(r_slot_q.gen, r_idx);
                    end
                    gha_pkg::OP_FREE: begin
                        if (cur) begin
                            slot_wr_en         = 1'b1;
                            slot_wr_data.alive = 1'b0;
                            slot_wr_data.gen   = gha_pkg::t_gen'(r_slot_q.gen + 1'b1);
                            if (stack_count < gha_pkg::t_count'(gha_pkg::SLOT_COUNT)) begin
                                stack_cmd.push     = 1'b1;
                                stack_cmd.push_idx = r_idx;
                            end
                            res_status   = gha_pkg::STATUS_DONE;
                            res_is_valid = 1'b1;
                        end
                    end
                    gha_pkg::OP_CHECK: begin
                        if (cur) begin
                            res_status   = gha_pkg::STATUS_DONE;
                            res_is_valid = 1'b1;
                        end
                    end
                    default: begin
                        res_status = gha_pkg::STATUS_INVALID;
                    end
                endcase
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_slots_used <= '0;
            r_done       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_slots_used <= n_slots_used;
            r_done       <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && start) begin
            r_op     <= i_op;
            r_handle <= i_handle;
            r_idx    <= i_handle[gha_pkg::INDEX_WIDTH-1:0];
        end else if (r_state == ST_POP) begin
            r_idx    <= stack_top;
        end
        if (res_valid) begin
            r_status     <= res_status;
            r_new_handle <= res_handle;
            r_is_valid   <= res_is_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_wr_en) begin
            r_slot_mem[slot_wr_addr] <= slot_wr_data;
        end
        if (slot_rd_en) begin
            r_slot_q <= r_slot_mem[slot_rd_addr];
        end
    end

    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_new_handle = r_new_handle;
    assign o_is_valid   = r_is_valid;

endmodule

### hw/rtl/gha_checker.sv
// Port-level checker for the generational handle allocator, bound to the top level.
`include "assert_macros.svh"

module gha_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     start,
    input logic                     busy,
    input logic                     o_done,
    input logic [1:0]               o_status,
    input logic [gha_pkg::HANDLE_WIDTH-1:0] o_new_handle,
    input logic                     o_is_valid
);

    logic w_status_done;
    logic w_handle_out;
    logic w_valid_out;
    logic w_full_out;
    logic w_clean;

    assign w_status_done = (o_status == gha_pkg::STATUS_DONE);
    assign w_handle_out  = o_done && (o_new_handle != '0);
    assign w_valid_out   = o_done && o_is_valid;
    assign w_full_out    = o_done && (o_status == gha_pkg::STATUS_FULL);
    assign w_clean       = (o_new_handle == '0) && !o_is_valid;

    `ASSERT_NEXT(a_accept_progress, i_clk, i_rst_n, start && !busy, busy || o_done)
    `ASSERT_IMPL(a_handle_only_done, i_clk, i_rst_n, w_handle_out, w_status_done)
    `ASSERT_IMPL(a_valid_only_done, i_clk, i_rst_n, w_valid_out, w_status_done)
    `ASSERT_IMPL(a_full_clean, i_clk, i_rst_n, w_full_out, w_clean)

endmodule

bind generational_handle_allocator_unit gha_checker u_gha_checker (.*);

### bench/generational_handle_allocator_unit_tb.sv
// Testbench for the generational handle allocator: directed and random requests against a predictor.
module generational_handle_allocator_unit_tb;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 200000;

    typedef struct {
        logic [1:0]       status;
        gha_pkg::t_handle new_handle;
        logic             is_valid;
    } t_outcome;

    class gha_scoreboard;
        bit              alive_tbl[gha_pkg::SLOT_COUNT];
        gha_pkg::t_gen   gen_tbl[gha_pkg::SLOT_COUNT];
        gha_pkg::t_index stack_tbl[gha_pkg::SLOT_COUNT];
        int unsigned     free_cnt;
        int unsigned     used_cnt;
        t_outcome        outcome_q[$];
        int              errors;
        int              full_hits;

        function new();
            free_cnt  = 0;
            used_cnt  = 0;
            errors    = 0;
            full_hits = 0;
        endfunction

        function gha_pkg::t_handle handle_of(gha_pkg::t_index idx);
            logic [63:0] wide;
            wide = (64'(gen_tbl[idx]) << gha_pkg::INDEX_WIDTH) | 64'(idx);
            return wide[gha_pkg::HANDLE_WIDTH-1:0];
        endfunction

        function bit is_current(gha_pkg::t_handle h);
            gha_pkg::t_index idx;
            idx = h[gha_pkg::INDEX_WIDTH-1:0];
            if (idx >= used_cnt || !alive_tbl[idx])
                return 1'b0;
            return handle_of(idx) == h;
        endfunction

        function t_outcome note_request(logic [1:0] op, gha_pkg::t_handle h);
            t_outcome        o;
            gha_pkg::t_index idx;
            o.status     = gha_pkg::STATUS_INVALID;
            o.new_handle = '0;
            o.is_valid   = 1'b0;
            case (op)
                gha_pkg::OP_ALLOC: begin
                    if (free_cnt > 0) begin
                        free_cnt--;
                        idx = stack_tbl[free_cnt];
                        alive_tbl[idx] = 1'b1;
                        o.new_handle   = handle_of(idx);
                        o.status       = gha_pkg::STATUS_DONE;
                    end else if (used_cnt < gha_pkg::SLOT_COUNT) begin
                        idx = gha_pkg::t_index'(used_cnt);
                        used_cnt++;
                        gen_tbl[idx]   = '0;
                        alive_tbl[idx] = 1'b1;
                        o.new_handle   = handle_of(idx);
                        o.status       = gha_pkg::STATUS_DONE;
                    end else begin
                        o.status = gha_pkg::STATUS_FULL;
                        full_hits++;
                    end
                end
                gha_pkg::OP_FREE: begin
                    if (is_current(h)) begin
                        idx = h[gha_pkg::INDEX_WIDTH-1:0];
                        alive_tbl[idx] = 1'b0;
                        gen_tbl[idx]   = gen_tbl[idx] + 1'b1;
                        if (free_cnt < gha_pkg::SLOT_COUNT) begin
                            stack_tbl[free_cnt] = idx;
                            free_cnt++;
                        end
                        o.status   = gha_pkg::STATUS_DONE;
                        o.is_valid = 1'b1;
                    end
                end
                gha_pkg::OP_CHECK: begin
                    if (is_current(h)) begin
                        o.status   = gha_pkg::STATUS_DONE;
                        o.is_valid = 1'b1;
                    end
                end
                default: ;
            endcase
            outcome_q.insert(outcome_q.size(), o);
            return o;
        endfunction

        task report(string what);
            errors++;
            $display("mismatch at %0t: %s", $realtime, what);
        endtask

        task check_result(logic [1:0] status, gha_pkg::t_handle nh, logic valid);
            t_outcome exp;
            if (outcome_q.size() == 0) begin
                report("result with nothing pending");
            end else begin
                exp = outcome_q.pop_front();
                if (status !== exp.status)
                    report($sformatf("status %0d, want %0d", status, exp.status));
                if (nh !== exp.new_handle)
                    report($sformatf("new_handle %h, want %h", nh, exp.new_handle));
                if (valid !== exp.is_valid)
                    report($sformatf("is_valid %0b, want %0b", valid, exp.is_valid));
            end
        endtask
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [1:0]       i_op;
    gha_pkg::t_handle i_handle;
    logic             o_done;
    logic [1:0]       o_status;
    gha_pkg::t_handle o_new_handle;
    logic             o_is_valid;

    gha_scoreboard    sb = new();
    gha_pkg::t_handle live_q[$];
    gha_pkg::t_handle stale_q[$];
    int               cycle_cnt = 0;
    int               sent_cnt  = 0;
    bit               no_idle   = 1'b0;

    generational_handle_allocator_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_op        (i_op),
        .i_handle    (i_handle),
        .o_done      (o_done),
        .o_status    (o_status),
        .o_new_handle(o_new_handle),
        .o_is_valid  (o_is_valid)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            sb.check_result(o_status, o_new_handle, o_is_valid);
    end

    task automatic transfer_item(input logic [1:0] op, input gha_pkg::t_handle h,
                                 output t_outcome exp);
        int gap;
        int k;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start    <= 1'b1;
        i_op     <= op;
        i_handle <= h;
        do @(posedge i_clk); while (busy);
        exp = sb.note_request(op, h);
        sent_cnt++;
        if (sent_cnt % 150 == 0)
            no_idle = !no_idle;
        if (op == gha_pkg::OP_ALLOC && exp.status == gha_pkg::STATUS_DONE)
            live_q.insert(live_q.size(), exp.new_handle);
        if (op == gha_pkg::OP_FREE && exp.is_valid) begin
            for (k = 0; k < live_q.size(); k++) begin
                if (live_q[k] == h) begin
                    live_q.delete(k);
                    break;
                end
            end
            stale_q.insert(stale_q.size(), h);
            if (stale_q.size() > 64)
                void'(stale_q.pop_front());
        end
    endtask

    task automatic random_item();
        t_outcome         exp;
        int               r;
        int               k;
        logic [1:0]       op;
        gha_pkg::t_handle h;
        r  = $urandom_range(0, 99);
        op = ($urandom_range(0, 1) == 0) ? gha_pkg::OP_FREE : gha_pkg::OP_CHECK;
        h  = $urandom;
        if (r < 40 || (r < 75 && live_q.size() == 0)) begin
            op = gha_pkg::OP_ALLOC;
        end else if (r < 62) begin
            op = gha_pkg::OP_FREE;
            h  = live_q[$urandom_range(0, live_q.size() - 1)];
        end else if (r < 75) begin
            op = gha_pkg::OP_CHECK;
            h  = live_q[$urandom_range(0, live_q.size() - 1)];
        end else if (r < 85) begin
            if (stale_q.size() > 0)
                h = stale_q[$urandom_range(0, stale_q.size() - 1)];
        end else if (r < 95) begin
            k = $urandom_range(0, sb.used_cnt + 1);
            h[gha_pkg::INDEX_WIDTH-1:0] = gha_pkg::t_index'(k);
            if ($urandom_range(0, 1) == 0)
                h[gha_pkg::HANDLE_WIDTH-1:gha_pkg::INDEX_WIDTH] =
                    gha_pkg::t_gen'($urandom_range(0, 3));
        end else begin
            op = OP_UNUSED;
        end
        transfer_item(op, h, exp);
    endtask

    initial begin
        t_outcome a0;
        t_outcome a1;
        t_outcome tmp;
        i_rst_n  = 1'b0;
        start    = 1'b0;
        i_op     = gha_pkg::OP_ALLOC;
        i_handle = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        transfer_item(gha_pkg::OP_ALLOC, '0, a0);
        transfer_item(gha_pkg::OP_ALLOC, '1, a1);
        transfer_item(gha_pkg::OP_CHECK, a0.new_handle, tmp);
        transfer_item(gha_pkg::OP_CHECK,
                      a0.new_handle ^ (gha_pkg::t_handle'(1) << gha_pkg::INDEX_WIDTH), tmp);
        transfer_item(gha_pkg::OP_CHECK, gha_pkg::t_handle'(gha_pkg::SLOT_COUNT - 1), tmp);
        transfer_item(gha_pkg::OP_FREE, gha_pkg::t_handle'(gha_pkg::SLOT_COUNT - 1), tmp);
        transfer_item(gha_pkg::OP_FREE, a0.new_handle, tmp);
        transfer_item(gha_pkg::OP_FREE, a0.new_handle, tmp);
        transfer_item(gha_pkg::OP_CHECK, a0.new_handle, tmp);
        transfer_item(gha_pkg::OP_FREE, a1.new_handle, tmp);
        transfer_item(gha_pkg::OP_ALLOC, '0, tmp);
        transfer_item(gha_pkg::OP_ALLOC, '0, tmp);
        transfer_item(gha_pkg::OP_ALLOC, '0, tmp);
        transfer_item(gha_pkg::OP_CHECK, tmp.new_handle, tmp);
        transfer_item(gha_pkg::OP_CHECK, '1, tmp);
        transfer_item(gha_pkg::OP_FREE, '1, tmp);
        transfer_item(OP_UNUSED, '1, tmp);
        transfer_item(OP_UNUSED, '0, tmp);
        transfer_item(gha_pkg::OP_CHECK, '0, tmp);

        repeat (500) random_item();
        while (sb.full_hits < 4)
            transfer_item(gha_pkg::OP_ALLOC, $urandom, tmp);
        transfer_item(gha_pkg::OP_CHECK, '1, tmp);
        repeat (500) random_item();

        @(negedge i_clk);
        start <= 1'b0;
        while (sb.outcome_q.size() != 0)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
